// ===== src/svp_pkg.sv =====
package svp_pkg;

   localparam int XW = 34;
   localparam int RW = 34;
   localparam int MAX_STEPS = 24;
   localparam int DIV_NUM_W = 62;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_Q_W = 34;

   localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [XW-1:0] ONE_Q30 = 34'sd1073741824;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SUMSQ,
      SEQ_SQRT,
      SEQ_PREP,
      SEQ_DIV,
      SEQ_STORE,
      SEQ_AXIS
   } seq_state_type;

   typedef enum logic [1:0] {
      CSR_BASE_X = 2'd0,
      CSR_BASE_Y = 2'd1,
      CSR_BASE_Z = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [15:0]          len;
      logic [1:0]           qt;
      logic [1:0]           qp;
      logic signed [XW-1:0] xt;
      logic signed [XW-1:0] yt;
      logic signed [XW-1:0] zt;
      logic signed [XW-1:0] xp;
      logic signed [XW-1:0] yp;
      logic signed [XW-1:0] zp;
   } cordic_type;

   typedef struct packed {
      logic                busy;
      logic                zero;
      logic                to_x;
      logic [8:0][RW-1:0]  r;
   } rot_type;

   function automatic logic signed [XW-1:0] atan_entry(input int i);
      logic signed [XW-1:0] a;
      case (i)
         0:  a = 34'sd536870912;
         1:  a = 34'sd316933406;
         2:  a = 34'sd167458907;
         3:  a = 34'sd85004756;
         4:  a = 34'sd42667331;
         5:  a = 34'sd21354465;
         6:  a = 34'sd10679838;
         7:  a = 34'sd5340245;
         8:  a = 34'sd2670163;
         9:  a = 34'sd1335087;
         10: a = 34'sd667544;
         11: a = 34'sd333772;
         12: a = 34'sd166886;
         13: a = 34'sd83443;
         14: a = 34'sd41722;
         15: a = 34'sd20861;
         16: a = 34'sd10430;
         17: a = 34'sd5215;
         18: a = 34'sd2608;
         19: a = 34'sd1304;
         20: a = 34'sd652;
         21: a = 34'sd326;
         22: a = 34'sd163;
         23: a = 34'sd81;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ===== src/svp_if.sv =====
interface svp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] length;
   logic [15:0] polar_angle;
   logic [15:0] azimuth_angle;

   modport source (output valid, length, polar_angle, azimuth_angle, input ready);
   modport sink (input valid, length, polar_angle, azimuth_angle, output ready);
endinterface

interface svp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] out_x;
   logic signed [16:0] out_y;
   logic signed [16:0] out_z;
   logic               status;

   modport source (output valid, out_x, out_y, out_z, status, input ready);
   modport sink (input valid, out_x, out_y, out_z, status, output ready);
endinterface

// ===== src/svp_cordic_cell.sv =====
module svp_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  svp_pkg::cordic_type up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output svp_pkg::cordic_type dn_data
);

   localparam logic signed [svp_pkg::XW-1:0] ATAN = svp_pkg::atan_entry(STEP);

   logic                valid_ff;
   svp_pkg::cordic_type data_ff;
   svp_pkg::cordic_type data_in;

   always_comb begin
      data_in = up_data;
      if (!up_data.zt[svp_pkg::XW-1]) begin
         data_in.xt = up_data.xt - (up_data.yt >>> STEP);
         data_in.yt = up_data.yt + (up_data.xt >>> STEP);
         data_in.zt = up_data.zt - ATAN;
      end else begin
         data_in.xt = up_data.xt + (up_data.yt >>> STEP);
         data_in.yt = up_data.yt - (up_data.xt >>> STEP);
         data_in.zt = up_data.zt + ATAN;
      end
      if (!up_data.zp[svp_pkg::XW-1]) begin
         data_in.xp = up_data.xp - (up_data.yp >>> STEP);
         data_in.yp = up_data.yp + (up_data.xp >>> STEP);
         data_in.zp = up_data.zp - ATAN;
      end else begin
         data_in.xp = up_data.xp + (up_data.yp >>> STEP);
         data_in.yp = up_data.yp - (up_data.xp >>> STEP);
         data_in.zp = up_data.zp + ATAN;
      end
   end

   assign up_ready = ~valid_ff | dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== src/svp_div.sv =====
module svp_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [svp_pkg::DIV_NUM_W-1:0] num,
   input  logic [svp_pkg::DIV_DEN_W-1:0] den,
   output logic                          done,
   output logic [svp_pkg::DIV_Q_W-1:0]   quot,
   output logic                          ovf
);

   localparam int CW = $clog2(svp_pkg::DIV_NUM_W);

   logic                          run_ff;
   logic                          done_ff;
   logic [CW-1:0]                 cnt_ff;
   logic [svp_pkg::DIV_NUM_W-1:0] num_ff;
   logic [svp_pkg::DIV_DEN_W-1:0] den_ff;
   logic [svp_pkg::DIV_DEN_W-1:0] rem_ff;
   logic [svp_pkg::DIV_Q_W-1:0]   quo_ff;
   logic                          ovf_ff;
   logic [svp_pkg::DIV_DEN_W:0]   trial;
   logic [svp_pkg::DIV_DEN_W:0]   diff;
   logic                          ge;

   assign trial = {rem_ff, num_ff[svp_pkg::DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            if (cnt_ff == CW'(svp_pkg::DIV_NUM_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (run_ff) begin
         num_ff <= {num_ff[svp_pkg::DIV_NUM_W-2:0], 1'b0};
         rem_ff <= ge ? diff[svp_pkg::DIV_DEN_W-1:0] : trial[svp_pkg::DIV_DEN_W-1:0];
         quo_ff <= {quo_ff[svp_pkg::DIV_Q_W-2:0], ge};
         ovf_ff <= ovf_ff | quo_ff[svp_pkg::DIV_Q_W-1];
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign ovf  = ovf_ff;

endmodule

// ===== src/svp_setup.sv =====
module svp_setup (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_write_data,
   output svp_pkg::rot_type rot
);

   localparam int RW = svp_pkg::RW;
   localparam logic [3:0] JOB_LAST_N = 4'd2;
   localparam logic [3:0] JOB_R0     = 4'd3;
   localparam logic [3:0] JOB_LAST   = 4'd11;

   svp_pkg::seq_state_type state_ff, state_in;

   logic signed [15:0] bx_ff, by_ff, bz_ff;
   logic [3:0]         job_ff;
   logic [4:0]         cnt_ff;
   logic [31:0]        s_ff;
   logic [33:0]        rem_ff;
   logic [31:0]        root_ff;
   logic               zero_ff;
   logic               to_x_ff;
   logic signed [31:0] n0_ff, n1_ff, n2_ff;
   logic signed [31:0] v0_ff, v1_ff, v2_ff;
   logic signed [31:0] c_ff;
   logic [8:0][RW-1:0] r_ff;

   logic               div_start, div_done, div_ovf;
   logic [svp_pkg::DIV_NUM_W-1:0] div_num;
   logic [svp_pkg::DIV_DEN_W-1:0] div_den;
   logic [svp_pkg::DIV_Q_W-1:0]   div_quot;

   logic [31:0]        sumsq;
   logic               base_zero;
   logic [16:0]        abs_x, abs_z, abs_sel;
   logic signed [15:0] sel_b;
   logic [35:0]        sq_rem, sq_trial, sq_diff;
   logic               sq_ge;
   logic signed [31:0] va, vb;
   logic [30:0]        ma, mb;
   logic [31:0]        qsat;
   logic signed [31:0] n_new;
   logic signed [RW-1:0] qs, extra;
   logic [3:0]         r_idx;
   logic signed [32:0] dsum;

   function automatic logic [16:0] abs17(input logic signed [15:0] a);
      logic signed [16:0] e;
      e = {a[15], a};
      return a[15] ? 17'(-e) : 17'(e);
   endfunction

   function automatic logic [30:0] mag31(input logic signed [31:0] a);
      logic [31:0] m;
      m = a[31] ? 32'(-a) : 32'(a);
      return m[30:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         bx_ff <= 16'sd0;
         by_ff <= 16'sd0;
         bz_ff <= 16'sd16384;
      end else if (csr_write_enable) begin
         case (svp_pkg::csr_index_type'(csr_index))
            svp_pkg::CSR_BASE_X: bx_ff <= csr_write_data;
            svp_pkg::CSR_BASE_Y: by_ff <= csr_write_data;
            svp_pkg::CSR_BASE_Z: bz_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign sumsq     = 32'(32'(bx_ff) * 32'(bx_ff)) + 32'(32'(by_ff) * 32'(by_ff))
                    + 32'(32'(bz_ff) * 32'(bz_ff));
   assign base_zero = (bx_ff == 16'sd0) && (by_ff == 16'sd0) && (bz_ff == 16'sd0);
   assign abs_x     = abs17(bx_ff);
   assign abs_z     = abs17(bz_ff);

   assign sq_rem   = {rem_ff, s_ff[31:30]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign sq_diff  = sq_rem - sq_trial;
   assign sq_ge    = sq_rem >= sq_trial;

   always_comb begin
      case (job_ff)
         4'd0:    sel_b = bx_ff;
         4'd1:    sel_b = by_ff;
         default: sel_b = bz_ff;
      endcase
      abs_sel = abs17(sel_b);
      case (job_ff)
         4'd3:    begin va = v0_ff; vb = v0_ff; extra = RW'(c_ff);   end
         4'd4:    begin va = v0_ff; vb = v1_ff; extra = RW'(-v2_ff); end
         4'd5:    begin va = v0_ff; vb = v2_ff; extra = RW'(v1_ff);  end
         4'd6:    begin va = v1_ff; vb = v0_ff; extra = RW'(v2_ff);  end
         4'd7:    begin va = v1_ff; vb = v1_ff; extra = RW'(c_ff);   end
         4'd8:    begin va = v1_ff; vb = v2_ff; extra = RW'(-v0_ff); end
         4'd9:    begin va = v2_ff; vb = v0_ff; extra = RW'(-v1_ff); end
         4'd10:   begin va = v2_ff; vb = v1_ff; extra = RW'(v0_ff);  end
         4'd11:   begin va = v2_ff; vb = v2_ff; extra = RW'(c_ff);   end
         default: begin va = v0_ff; vb = v0_ff; extra = '0;          end
      endcase
      ma = mag31(va);
      mb = mag31(vb);
      dsum = 33'sd1073741824 + 33'(c_ff);
      if (job_ff <= JOB_LAST_N) begin
         div_num = {abs_sel[15:0], 46'd0};
         div_den = root_ff;
      end else begin
         div_num = {31'd0, ma} * {31'd0, mb};
         div_den = (dsum < 33'sd1) ? 32'd1 : dsum[31:0];
      end
      qsat  = (div_ovf || div_quot > 34'd1073741824) ? 32'h4000_0000 : div_quot[31:0];
      n_new = sel_b[15] ? -$signed(qsat) : $signed(qsat);
      qs    = (va[31] ^ vb[31]) ? -$signed(div_quot) : $signed(div_quot);
      r_idx = job_ff - JOB_R0;
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      case (state_ff)
         svp_pkg::SEQ_IDLE:  ;
         svp_pkg::SEQ_SUMSQ: state_in = base_zero ? svp_pkg::SEQ_IDLE : svp_pkg::SEQ_SQRT;
         svp_pkg::SEQ_SQRT: begin
            if (cnt_ff == 5'd31) state_in = svp_pkg::SEQ_PREP;
         end
         svp_pkg::SEQ_PREP: begin
            div_start = 1'b1;
            state_in  = svp_pkg::SEQ_DIV;
         end
         svp_pkg::SEQ_DIV: begin
            if (div_done) state_in = svp_pkg::SEQ_STORE;
         end
         svp_pkg::SEQ_STORE: begin
            if (job_ff == JOB_LAST_N) state_in = svp_pkg::SEQ_AXIS;
            else if (job_ff == JOB_LAST) state_in = svp_pkg::SEQ_IDLE;
            else state_in = svp_pkg::SEQ_PREP;
         end
         svp_pkg::SEQ_AXIS:  state_in = svp_pkg::SEQ_PREP;
         default:            state_in = svp_pkg::SEQ_IDLE;
      endcase
      if (csr_write_enable) state_in = svp_pkg::SEQ_SUMSQ;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= svp_pkg::SEQ_SUMSQ;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff  <= '0;
         cnt_ff  <= '0;
         zero_ff <= 1'b0;
         to_x_ff <= 1'b0;
      end else begin
         case (state_ff)
            svp_pkg::SEQ_SUMSQ: begin
               job_ff  <= '0;
               cnt_ff  <= '0;
               zero_ff <= base_zero;
               to_x_ff <= abs_x < abs_z;
            end
            svp_pkg::SEQ_SQRT:  cnt_ff <= cnt_ff + 1'b1;
            svp_pkg::SEQ_STORE: job_ff <= job_ff + 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         svp_pkg::SEQ_SUMSQ: begin
            s_ff    <= sumsq;
            rem_ff  <= '0;
            root_ff <= '0;
         end
         svp_pkg::SEQ_SQRT: begin
            s_ff    <= {s_ff[29:0], 2'b00};
            rem_ff  <= sq_ge ? sq_diff[33:0] : sq_rem[33:0];
            root_ff <= {root_ff[30:0], sq_ge};
         end
         svp_pkg::SEQ_STORE: begin
            case (job_ff)
               4'd0:    n0_ff <= n_new;
               4'd1:    n1_ff <= n_new;
               4'd2:    n2_ff <= n_new;
               default: r_ff[r_idx] <= qs + extra;
            endcase
         end
         svp_pkg::SEQ_AXIS: begin
            if (to_x_ff) begin
               v0_ff <= 32'sd0;
               v1_ff <= -n2_ff;
               v2_ff <= n1_ff;
               c_ff  <= n0_ff;
            end else begin
               v0_ff <= -n1_ff;
               v1_ff <= n0_ff;
               v2_ff <= 32'sd0;
               c_ff  <= n2_ff;
            end
         end
         default: ;
      endcase
   end

   svp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot),
      .ovf   (div_ovf)
   );

   assign rot.busy = state_ff != svp_pkg::SEQ_IDLE;
   assign rot.zero = zero_ff;
   assign rot.to_x = to_x_ff;
   assign rot.r    = r_ff;

endmodule

// ===== src/spherical_vector_placer.sv =====
// Spherical vector placer: turns (length, polar angle, azimuth) into a Cartesian
// vector whose polar axis is the base vector held in csr registers 0..2 (base_x,
// base_y, base_z, Q2.14). One transfer per clock is taken once the rotation matrix
// is ready, unless rsp_port.ready holds the pipeline back; each result passes
// through CORDIC_STEPS CORDIC cells and seven map/multiply/round stages, in order.
// After reset and after every csr write the matrix is rebuilt by a shared
// bit-serial square root and divider, while req_port.ready stays low. A zero
// base vector gives status 1 and zero outputs.
module spherical_vector_placer #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic             clock,
   input  logic             reset,
   svp_req_if.sink          req_port,
   svp_rsp_if.source        rsp_port,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_write_data
);

   localparam int XW = svp_pkg::XW;

   svp_pkg::rot_type    rot;
   svp_pkg::cordic_type cell_data  [CORDIC_STEPS+1];
   logic                cell_valid [CORDIC_STEPS+1];
   logic                cell_ready [CORDIC_STEPS+1];

   logic en_a, en_b, en_c, en_d, en_e, en_f, en_g;

   logic               a_valid_ff;
   logic [15:0]        a_len_ff;
   logic signed [31:0] a_ct_ff, a_st_ff, a_cp_ff, a_sp_ff;
   logic signed [31:0] ct_in, st_in, cp_in, sp_in;

   logic               b_valid_ff;
   logic [15:0]        b_len_ff;
   logic signed [31:0] b_ct_ff;
   logic signed [63:0] b_pc_ff, b_ps_ff;

   logic               c_valid_ff;
   logic [15:0]        c_len_ff;
   logic signed [31:0] c_t_ff [3];
   logic signed [31:0] rc, rs;

   logic               d_valid_ff;
   logic signed [48:0] d_m_ff [3];

   logic               e_valid_ff;
   logic signed [31:0] e_l_ff [3];

   logic               f_valid_ff;
   logic signed [65:0] f_p_ff [9];

   logic               g_valid_ff;
   logic signed [16:0] g_x_ff, g_y_ff, g_z_ff;
   logic               g_status_ff;
   logic signed [16:0] o_in [3];

   function automatic logic [1:0] quad(input logic [15:0] ang);
      logic [15:0] s;
      s = ang + 16'h2000;
      return s[15:14];
   endfunction

   function automatic logic signed [XW-1:0] phase(input logic [15:0] ang);
      logic [15:0] d;
      d = ang - {quad(ang), 14'd0};
      return {{(XW-32){d[15]}}, d, 16'h0000};
   endfunction

   function automatic logic signed [31:0] clamp1(input logic signed [XW-1:0] v);
      logic signed [31:0] r;
      if (v > svp_pkg::ONE_Q30) r = 32'sh4000_0000;
      else if (v < -svp_pkg::ONE_Q30) r = -32'sh4000_0000;
      else r = 32'(v);
      return r;
   endfunction

   function automatic void qmap(input logic [1:0] q, input logic signed [31:0] x,
                                input logic signed [31:0] y,
                                output logic signed [31:0] co,
                                output logic signed [31:0] si);
      case (q)
         2'd0:    begin co = x;  si = y;  end
         2'd1:    begin co = -y; si = x;  end
         2'd2:    begin co = -x; si = -y; end
         default: begin co = y;  si = -x; end
      endcase
   endfunction

   function automatic logic signed [16:0] finish(input logic signed [67:0] acc);
      logic signed [67:0] o;
      logic signed [16:0] r;
      o = (acc + 68'sh200_0000_0000) >>> 42;
      if (o > 68'sd65535) r = 17'sd65535;
      else if (o < -68'sd65536) r = -17'sd65536;
      else r = 17'(o);
      return r;
   endfunction

   svp_setup u_setup (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rot              (rot)
   );

   assign cell_data[0] = '{len: req_port.length,
                           qt:  quad(req_port.polar_angle),
                           qp:  quad(req_port.azimuth_angle),
                           xt:  svp_pkg::CORDIC_GAIN,
                           yt:  '0,
                           zt:  phase(req_port.polar_angle),
                           xp:  svp_pkg::CORDIC_GAIN,
                           yp:  '0,
                           zp:  phase(req_port.azimuth_angle)};

   assign cell_valid[0]  = req_port.valid & ~rot.busy;
   assign req_port.ready = cell_ready[0] & ~rot.busy;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
      svp_cordic_cell #(.STEP(k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (cell_valid[k]),
         .up_ready (cell_ready[k]),
         .up_data  (cell_data[k]),
         .dn_valid (cell_valid[k+1]),
         .dn_ready (cell_ready[k+1]),
         .dn_data  (cell_data[k+1])
      );
   end

   assign en_g = ~g_valid_ff | rsp_port.ready;
   assign en_f = ~f_valid_ff | en_g;
   assign en_e = ~e_valid_ff | en_f;
   assign en_d = ~d_valid_ff | en_e;
   assign en_c = ~c_valid_ff | en_d;
   assign en_b = ~b_valid_ff | en_c;
   assign en_a = ~a_valid_ff | en_b;
   assign cell_ready[CORDIC_STEPS] = en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else begin
         if (en_a) a_valid_ff <= cell_valid[CORDIC_STEPS];
         if (en_b) b_valid_ff <= a_valid_ff;
         if (en_c) c_valid_ff <= b_valid_ff;
         if (en_d) d_valid_ff <= c_valid_ff;
         if (en_e) e_valid_ff <= d_valid_ff;
         if (en_f) f_valid_ff <= e_valid_ff;
         if (en_g) g_valid_ff <= f_valid_ff;
      end
   end

   always_comb begin
      qmap(cell_data[CORDIC_STEPS].qt, clamp1(cell_data[CORDIC_STEPS].xt),
           clamp1(cell_data[CORDIC_STEPS].yt), ct_in, st_in);
      qmap(cell_data[CORDIC_STEPS].qp, clamp1(cell_data[CORDIC_STEPS].xp),
           clamp1(cell_data[CORDIC_STEPS].yp), cp_in, sp_in);
      rc = 32'((b_pc_ff + 64'sd536870912) >>> 30);
      rs = 32'((b_ps_ff + 64'sd536870912) >>> 30);
      for (int i = 0; i < 3; i++) begin
         o_in[i] = finish(68'(f_p_ff[3*i]) + 68'(f_p_ff[3*i+1]) + 68'(f_p_ff[3*i+2]));
      end
   end

   always_ff @(posedge clock) begin
      if (en_a && cell_valid[CORDIC_STEPS]) begin
         a_len_ff <= cell_data[CORDIC_STEPS].len;
         a_ct_ff  <= ct_in;
         a_st_ff  <= st_in;
         a_cp_ff  <= cp_in;
         a_sp_ff  <= sp_in;
      end
      if (en_b && a_valid_ff) begin
         b_len_ff <= a_len_ff;
         b_ct_ff  <= a_ct_ff;
         b_pc_ff  <= a_cp_ff * a_st_ff;
         b_ps_ff  <= a_sp_ff * a_st_ff;
      end
      if (en_c && b_valid_ff) begin
         c_len_ff <= b_len_ff;
         if (rot.to_x) begin
            c_t_ff[0] <= b_ct_ff;
            c_t_ff[1] <= rc;
            c_t_ff[2] <= rs;
         end else begin
            c_t_ff[0] <= rc;
            c_t_ff[1] <= rs;
            c_t_ff[2] <= b_ct_ff;
         end
      end
      if (en_d && c_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            d_m_ff[i] <= $signed({1'b0, c_len_ff}) * c_t_ff[i];
         end
      end
      if (en_e && d_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            e_l_ff[i] <= 32'((d_m_ff[i] + 49'sd131072) >>> 18);
         end
      end
      if (en_f && e_valid_ff) begin
         for (int i = 0; i < 9; i++) begin
            f_p_ff[i] <= $signed(rot.r[i]) * e_l_ff[i % 3];
         end
      end
      if (en_g && f_valid_ff) begin
         g_status_ff <= rot.zero;
         g_x_ff      <= rot.zero ? 17'sd0 : o_in[0];
         g_y_ff      <= rot.zero ? 17'sd0 : o_in[1];
         g_z_ff      <= rot.zero ? 17'sd0 : o_in[2];
      end
   end

   assign rsp_port.valid  = g_valid_ff;
   assign rsp_port.out_x  = g_x_ff;
   assign rsp_port.out_y  = g_y_ff;
   assign rsp_port.out_z  = g_z_ff;
   assign rsp_port.status = g_status_ff;

`ifndef NO_ASSERTIONS
   a_no_transfer_in_setup: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |-> !rot.busy)
      else $error("input transfer while rotation setup runs");

   a_zero_base_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.status) |->
      (rsp_port.out_x == 17'sd0 && rsp_port.out_y == 17'sd0 && rsp_port.out_z == 17'sd0))
      else $error("zero base status with nonzero result");

   a_setup_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> rot.busy)
      else $error("rotation setup not started after reset");
`endif

endmodule

// ===== verif/spherical_vector_placer_tb.sv =====
`timescale 1ns / 1ps

module spherical_vector_placer_tb;

   localparam int STEPS = 16;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic signed [16:0] x;
      logic signed [16:0] y;
      logic signed [16:0] z;
      logic               status;
   } placed_vec_type;

   class placement_scoreboard;
      logic signed [15:0] base [3];
      placed_vec_type     pending[$];
      int                 errors;

      function new();
         base[0] = 16'sd0;
         base[1] = 16'sd0;
         base[2] = 16'sd16384;
         errors = 0;
      endfunction

      function void set_base(svp_pkg::csr_index_type idx, logic [15:0] val);
         base[idx] = val;
      endfunction

      function longint rnd_shift(longint v, int s);
         return (v + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n = n - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function void trig(logic [15:0] ang, output longint co, output longint si);
         longint atans [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                                21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                                333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                                1304, 652, 326, 163, 81};
         logic [31:0] ph, sum, d;
         logic [1:0]  q;
         longint      x, y, z, dx, dy;
         ph = {ang, 16'h0000};
         sum = ph + 32'h2000_0000;
         q = sum[31:30];
         d = ph - {q, 30'd0};
         z = longint'($signed(d));
         x = 652032874;
         y = 0;
         for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atans[i];
            end else begin
               x += dx; y -= dy; z += atans[i];
            end
         end
         if (x > (64'sd1 <<< 30)) x = 64'sd1 <<< 30;
         if (x < -(64'sd1 <<< 30)) x = -(64'sd1 <<< 30);
         if (y > (64'sd1 <<< 30)) y = 64'sd1 <<< 30;
         if (y < -(64'sd1 <<< 30)) y = -(64'sd1 <<< 30);
         case (q)
            2'd0: begin co = x; si = y; end
            2'd1: begin co = -y; si = x; end
            2'd2: begin co = -x; si = -y; end
            default: begin co = y; si = -x; end
         endcase
      endfunction

      function logic signed [16:0] sat17(longint v);
         if (v > 65535) v = 65535;
         if (v < -65536) v = -65536;
         return v[16:0];
      endfunction

      function placed_vec_type place(logic [15:0] len, logic [15:0] pol, logic [15:0] az);
         placed_vec_type  r;
         longint          b [3], n [3], v [3], t [3], lv [3], rot [3][3];
         longint          c, den, ct, st, cp, sp, acc;
         longint unsigned s2, bn, m, q;
         bit              to_x;
         for (int i = 0; i < 3; i++) b[i] = longint'(base[i]);
         if (b[0] == 0 && b[1] == 0 && b[2] == 0) begin
            r.x = 0; r.y = 0; r.z = 0; r.status = 1'b1;
            return r;
         end
         s2 = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
         bn = int_sqrt(s2 << 32);
         for (int i = 0; i < 3; i++) begin
            m = b[i] < 0 ? -b[i] : b[i];
            q = (m << 46) / bn;
            if (q > (64'd1 << 30)) q = 64'd1 << 30;
            n[i] = b[i] < 0 ? -longint'(q) : longint'(q);
         end
         to_x = (b[0] < 0 ? -b[0] : b[0]) < (b[2] < 0 ? -b[2] : b[2]);
         if (to_x) begin
            v[0] = 0; v[1] = -n[2]; v[2] = n[1]; c = n[0];
         end else begin
            v[0] = -n[1]; v[1] = n[0]; v[2] = 0; c = n[2];
         end
         den = (64'sd1 <<< 30) + c;
         if (den < 1) den = 1;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               rot[i][j] = (i == j ? c : 0) + (v[i] * v[j]) / den;
         rot[0][1] -= v[2]; rot[0][2] += v[1];
         rot[1][0] += v[2]; rot[1][2] -= v[0];
         rot[2][0] -= v[1]; rot[2][1] += v[0];
         trig(pol, ct, st);
         trig(az, cp, sp);
         if (to_x) begin
            t[0] = ct;
            t[1] = rnd_shift(cp * st, 30);
            t[2] = rnd_shift(sp * st, 30);
         end else begin
            t[0] = rnd_shift(cp * st, 30);
            t[1] = rnd_shift(sp * st, 30);
            t[2] = ct;
         end
         for (int i = 0; i < 3; i++) lv[i] = rnd_shift(longint'(len) * t[i], 18);
         acc = rot[0][0] * lv[0] + rot[0][1] * lv[1] + rot[0][2] * lv[2];
         r.x = sat17(rnd_shift(acc, 42));
         acc = rot[1][0] * lv[0] + rot[1][1] * lv[1] + rot[1][2] * lv[2];
         r.y = sat17(rnd_shift(acc, 42));
         acc = rot[2][0] * lv[0] + rot[2][1] * lv[1] + rot[2][2] * lv[2];
         r.z = sat17(rnd_shift(acc, 42));
         r.status = 1'b0;
         return r;
      endfunction

      function void note_request(logic [15:0] len, logic [15:0] pol, logic [15:0] az);
         pending.push_back(place(len, pol, az));
      endfunction

      function void check_response(logic signed [16:0] x, logic signed [16:0] y,
                                   logic signed [16:0] z, logic st);
         placed_vec_type e;
         if (pending.size() == 0) begin
            $error("unexpected response transfer x=%0d y=%0d z=%0d status=%0d",
                   x, y, z, st);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (x !== e.x) begin
            $error("out_x expected %0d actual %0d", e.x, x); errors++;
         end
         if (y !== e.y) begin
            $error("out_y expected %0d actual %0d", e.y, y); errors++;
         end
         if (z !== e.z) begin
            $error("out_z expected %0d actual %0d", e.z, z); errors++;
         end
         if (st !== e.status) begin
            $error("status expected %0d actual %0d", e.status, st); errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [15:0] csr_write_data;
   bit          req_idle_on;
   bit          rsp_idle_on;

   svp_req_if req_bus();
   svp_rsp_if rsp_bus();

   placement_scoreboard sb = new();

   spherical_vector_placer #(.CORDIC_STEPS(STEPS)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_bus),
      .rsp_port         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.length, req_bus.polar_angle, req_bus.azimuth_angle);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.out_x, rsp_bus.out_y, rsp_bus.out_z, rsp_bus.status);
      end
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_vector(logic [15:0] len, logic [15:0] pol, logic [15:0] az);
      int gap;
      gap = req_idle_on ? int'($urandom_range(0, 8)) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.length        <= len;
      req_bus.polar_angle   <= pol;
      req_bus.azimuth_angle <= az;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_base(logic [15:0] bx, logic [15:0] by, logic [15:0] bz);
      settle();
      csr_write_enable <= 1'b1;
      csr_index        <= svp_pkg::CSR_BASE_X;
      csr_write_data   <= bx;
      sb.set_base(svp_pkg::CSR_BASE_X, bx);
      @(posedge clock);
      csr_index        <= svp_pkg::CSR_BASE_Y;
      csr_write_data   <= by;
      sb.set_base(svp_pkg::CSR_BASE_Y, by);
      @(posedge clock);
      csr_index        <= svp_pkg::CSR_BASE_Z;
      csr_write_data   <= bz;
      sb.set_base(svp_pkg::CSR_BASE_Z, bz);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_burst(int count);
      logic [15:0] len;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         len = ($urandom_range(0, 7) == 0) ? 16'(16'hffff - 16'($urandom_range(0, 255)))
                                            : 16'($urandom_range(0, 65535));
         send_vector(len, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      end
   endtask

   initial begin
      int gap;
      wait (reset === 1'b0);
      forever begin
         gap = rsp_idle_on ? int'($urandom_range(0, 8)) : 0;
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin
      logic [15:0] angles [8] = '{16'd0, 16'd8192, 16'd16384, 16'd32768, 16'd49152,
                                  16'd57344, 16'd65535, 16'd24576};
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= svp_pkg::CSR_BASE_X;
      csr_write_data   <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.length   <= '0;
      req_bus.polar_angle   <= '0;
      req_bus.azimuth_angle <= '0;
      rsp_bus.ready    <= 1'b0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes and quadrant boundaries on the default base
      send_vector(16'h0000, 16'h0000, 16'h0000);
      send_vector(16'hffff, 16'hffff, 16'hffff);
      send_vector(16'hffff, 16'h4000, 16'h0000);
      send_vector(16'hffff, 16'hc000, 16'h8000);
      for (int i = 0; i < 8; i++)
         send_vector(16'h0100, angles[i], angles[7 - i]);
      for (int i = 0; i < 4; i++)
         send_vector(16'h8000, angles[2 * i], angles[2 * i + 1]);

      // zero base: status set, outputs zero
      load_base(16'h0000, 16'h0000, 16'h0000);
      send_vector(16'hffff, 16'h1234, 16'h4321);
      random_burst(30);

      // base antiparallel to Z, reference X
      load_base(16'h0000, 16'h0000, 16'h8000);
      send_vector(16'hffff, 16'h0000, 16'h0000);
      random_burst(80);

      // base along -X, reference Z
      load_base(16'h8000, 16'h0000, 16'h0000);
      send_vector(16'hffff, 16'h8000, 16'h0000);
      random_burst(80);

      load_base(16'h7fff, 16'h7fff, 16'h7fff);
      random_burst(80);
      load_base(16'h8000, 16'h8000, 16'h8000);
      random_burst(80);
      load_base(16'h0000, 16'h0001, 16'h0000);
      random_burst(60);
      load_base(16'h0001, 16'h8000, 16'h7fff);
      random_burst(60);
      for (int p = 0; p < 4; p++) begin
         load_base(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)));
         random_burst(50);
      end

      settle();
      if (sb.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
